>>> design/fr_pkg.sv
// fr_pkg: shared types for the fraction reducer.
// Holds the datapath operation codes and the datapath status word.
// No dependencies.
`default_nettype none

package fr_pkg;

  // Operation the sequencer asks of the datapath this cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_GCD_STEP,
    OP_DIV_STEP,
    OP_DIV2_INIT
  } op_t;

  // Flags the datapath reports back to the sequencer
  typedef struct packed {
    logic a_zero;   // binary GCD finished: a has reached zero
  } status_t;

endpackage

`default_nettype wire

>>> design/fr_datapath.sv
// fr_datapath: operand registers and the one shared subtractor of the
// fraction reducer. Runs binary GCD steps and restoring division steps.
// Depends on fr_pkg.
`default_nettype none

module fr_datapath #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic [W-1:0]     num,
  input  logic [W-1:0]     den,
  input  fr_pkg::op_t      op,
  output fr_pkg::status_t  status,
  output logic [W-1:0]     num_red,
  output logic [W-1:0]     den_red,
  output logic             neg
);
  import fr_pkg::*;

  localparam int KW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  dmag;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [KW-1:0] k;
  logic [W-1:0]  dvs;
  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  nr;

  logic [W-1:0]  num_mag;
  logic [W-1:0]  den_mag;
  logic [W:0]    sub_x;
  logic [W:0]    sub_y;
  logic [W:0]    diff;
  logic [W:0]    diff_neg;
  logic          borrow;

  // Input magnitudes; the most negative value maps to 2^(W-1) exactly
  assign num_mag = num[W-1] ? (~num + W'(1)) : num;
  assign den_mag = den[W-1] ? (~den + W'(1)) : den;

  // Shared subtractor: a - b for GCD, partial remainder - divisor for division
  always_comb begin
    case (op)
      OP_GCD_STEP: begin
        sub_x = {1'b0, a};
        sub_y = {1'b0, b};
      end
      default: begin
        sub_x = {r, q[W-1]};
        sub_y = {1'b0, dvs};
      end
    endcase
  end

  assign diff     = sub_x - sub_y;
  assign diff_neg = ~diff + (W+1)'(1);
  assign borrow   = diff[W];

  assign status.a_zero = (a == '0);

  // Operand registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        a    <= num_mag;
        b    <= den_mag;
        dmag <= den_mag;
        q    <= num_mag;
        k    <= '0;
        neg  <= num[W-1] ^ den[W-1];
      end
      OP_GCD_STEP: begin
        if (a == '0) begin
          // gcd found: restore common factors of two, start numerator divide
          dvs <= b << k;
          r   <= '0;
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + KW'(1);
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (!borrow) begin
          a <= diff[W:1];
        end else begin
          b <= diff_neg[W:1];
        end
      end
      OP_DIV_STEP: begin
        // restoring division: one quotient bit per cycle
        if (!borrow) begin
          r <= diff[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= sub_x[W-1:0];
          q <= {q[W-2:0], 1'b0};
        end
      end
      OP_DIV2_INIT: begin
        nr <= q;
        q  <= dmag;
        r  <= '0;
      end
      default: begin
      end
    endcase
  end

  assign num_red = nr;
  assign den_red = q;

endmodule

`default_nettype wire

>>> design/fraction_reducer_core.sv
// fraction_reducer_core: top level. Sequencer and result registers around
// fr_datapath, which holds the operands and the shared subtractor.
// Depends on fr_pkg and fr_datapath.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+---------------------
//   input    | numerator_in, denominator_in                 | start & !busy
//   result   | numerator_out, denominator_out, status       | done, one-cycle pulse
//
// One word passes from the accepting edge to the result edge through the binary
// GCD steps and two restoring divisions, which share the one subtractor in
// fr_datapath, with a swap state between the divisions and a finish state at the
// end. A zero denominator is answered the cycle after acceptance. For a nonzero
// denominator, busy is high from acceptance until the result strobe.
// rst is synchronous and clears the sequencer, busy and done.
// The receiver cannot stall: done is high for one cycle per word.
`default_nettype none

module fraction_reducer_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] numerator_in,
  input  logic signed [DATA_WIDTH-1:0] denominator_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] numerator_out,
  output logic        [DATA_WIDTH-2:0] denominator_out,
  output logic                         status
);
  import fr_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_SWAP,
    S_DIVD,
    S_FINISH
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  op_t             op;
  status_t         dp_status;
  logic [W-1:0]    num_red;
  logic [W-1:0]    den_red;
  logic            neg;
  logic            accept;

  assign accept = start && !busy;

  // Operation issued to the datapath
  always_comb begin
    case (state)
      S_IDLE:   op = (accept && denominator_in != '0) ? OP_LOAD : OP_IDLE;
      S_GCD:    op = OP_GCD_STEP;
      S_DIVN:   op = OP_DIV_STEP;
      S_SWAP:   op = OP_DIV2_INIT;
      S_DIVD:   op = OP_DIV_STEP;
      default:  op = OP_IDLE;
    endcase
  end

  fr_datapath #(
    .W (W)
  ) u_dp (
    .clk     (clk),
    .num     (numerator_in),
    .den     (denominator_in),
    .op      (op),
    .status  (dp_status),
    .num_red (num_red),
    .den_red (den_red),
    .neg     (neg)
  );

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (denominator_in == '0) begin
              done            <= 1'b1;
              status          <= 1'b1;
              numerator_out   <= '0;
              denominator_out <= '0;
            end else begin
              busy  <= 1'b1;
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (dp_status.a_zero) begin
            cnt   <= '0;
            state <= S_DIVN;
          end
        end
        S_DIVN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(W - 1)) begin
            state <= S_SWAP;
          end
        end
        S_SWAP: begin
          cnt   <= '0;
          state <= S_DIVD;
        end
        S_DIVD: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(W - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done            <= 1'b1;
          busy            <= 1'b0;
          status          <= 1'b0;
          numerator_out   <= neg ? (~num_red + W'(1)) : num_red;
          denominator_out <= den_red[W-2:0];
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
